### hdl/ssi_pkg.sv
// shared types, codes and constants for the shape segment intersection block
package ssi_pkg;

  localparam int AW = 70;

  localparam logic [1:0] OP_VERTEX  = 2'd0;
  localparam logic [1:0] OP_SEGMENT = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  localparam logic [2:0] CFG_POS_X  = 3'd0;
  localparam logic [2:0] CFG_POS_Y  = 3'd1;
  localparam logic [2:0] CFG_SIN    = 3'd2;
  localparam logic [2:0] CFG_COS    = 3'd3;
  localparam logic [2:0] CFG_SCALE  = 3'd4;
  localparam logic [2:0] CFG_NUM_V  = 3'd5;
  localparam logic [2:0] CFG_NUM_S  = 3'd6;

  localparam logic [4:0] CALC_LAST  = 5'd24;
  localparam logic [4:0] DIV_LAST   = 5'd15;
  localparam logic [4:0] PT_LAST    = 5'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEG, ST_VA, ST_VB, ST_VC, ST_CALC, ST_DIV, ST_PT, ST_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [4:0]         slot;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic [4:0]         first_vertex;
    logic [4:0]         second_vertex;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic [15:0]        t_out;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
  } out_t;

  typedef struct packed {
    logic               vtx_we;
    logic               seg_we;
    logic [4:0]         slot;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [4:0]         first;
    logic [4:0]         second;
  } store_wr_t;

endpackage

### hdl/shape_segment_intersection_top.sv
// top level of the shape versus line segment intersection block
// Usage: shape vertices (op 0) and vertex index pairs (op 1) are loaded as
// requests on the in_ channel; a query request (op 2) carries a segment and
// returns one result on the out_ channel: the first shape edge it properly
// crosses, with t and the crossing point. Every request returns one result;
// loads and unknown ops return all zeros.
// Configuration (pose, scale, counts) is written through cfg_we/cfg_index/
// cfg_wdata while no request is in flight.
// The block takes one request at a time. A query examines its edges in turn:
// each edge needs two vertex memory reads (after a segment read when
// segments are in use) and 18 passes through the single shared multiplier
// for the two vertex transforms and the areas; an edge that is hit also
// needs a restoring divider for t and two more products for the point.
// in_stall is high from acceptance until the result enters the output
// register; that register holds its result while out_stall is high, and the
// block waits in its final state until the register is free.
// Reset (rst_n low, synchronous) clears the control state and the output
// valid and returns the configuration to its defaults; memory contents are
// kept and are undefined until loaded.
module shape_segment_intersection_top #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_SEGMENTS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_wdata,
  input  logic          in_valid,
  output logic          in_stall,
  input  ssi_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ssi_pkg::out_t out_data
);

  localparam int AW   = ssi_pkg::AW;
  localparam int VAW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int SAW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int MAXE = (MAX_VERTICES > MAX_SEGMENTS) ? MAX_VERTICES : MAX_SEGMENTS;
  localparam int LW   = $clog2(MAXE + 1);

  function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] v);
    if ((v[AW-1:31] == '0) || (v[AW-1:31] == '1)) return v[31:0];
    return v[AW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  function automatic logic signed [34:0] rnd14(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] tmp;
    tmp = v + $signed(AW'(8192));
    return 35'(tmp >>> 14);
  endfunction

  // round(p, >>s) + off, saturated
  function automatic logic signed [31:0] rnd_add(input logic signed [68:0] p,
                                                 input logic signed [31:0] off,
                                                 input logic               by16);
    logic signed [AW-1:0] tmp;
    if (by16) begin
      tmp = AW'(p) + (AW'(off) <<< 16) + $signed(AW'(32768));
      return sat32(tmp >>> 16);
    end
    tmp = AW'(p) + (AW'(off) <<< 8) + $signed(AW'(128));
    return sat32(tmp >>> 8);
  endfunction

  function automatic logic [AW-1:0] absv(input logic signed [AW-1:0] v);
    return v[AW-1] ? AW'(-v) : AW'(v);
  endfunction

  // configuration
  logic signed [31:0] pos_x_r, pos_y_r;
  logic signed [15:0] sin_r, cos_r;
  logic [15:0]        scale_r;
  logic [5:0]         nv_r, ns_r;

  // control
  ssi_pkg::state_t state_r, state_nxt;
  logic [4:0]      step_r, step_nxt;
  logic [LW-1:0]   i_r, i_nxt, n_r, n_calc;
  logic            seg_mode_r;
  logic            out_valid_r, load_out;
  logic            in_acc, hit_now;

  // datapath
  logic signed [31:0] qx_r, qy_r, qex_r, qey_r;
  logic signed [31:0] vax_r, vay_r, vbx_r, vby_r;
  logic signed [31:0] cx_r, cy_r, dx_r, dy_r;
  logic signed [31:0] ux, uy;
  logic signed [34:0] rnd_r;
  logic signed [34:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [68:0] prod_r;
  logic signed [AW-1:0] acc_r, a1_r, a2_r, a3_r, a4_r, dd_r, prod_w;
  logic [AW:0]        num_r, num_sh;
  logic [AW-1:0]      den_r;
  logic [15:0]        t_r;
  logic               res_hit_r;
  logic [15:0]        res_t_r;
  logic signed [31:0] res_hx_r, res_hy_r;
  ssi_pkg::out_t      out_data_r;
  logic [VAW-1:0]     s_idx, e_idx, e_idx_r, vtx_raddr, seg_first, seg_second;
  logic signed [31:0] vtx_x, vtx_y;
  ssi_pkg::store_wr_t wr;

  assign in_stall  = (state_r != ssi_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      sin_r   <= '0;
      cos_r   <= 16'sd16384;
      scale_r <= 16'd256;
      nv_r    <= '0;
      ns_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ssi_pkg::CFG_POS_X: pos_x_r <= cfg_wdata;
        ssi_pkg::CFG_POS_Y: pos_y_r <= cfg_wdata;
        ssi_pkg::CFG_SIN:   sin_r   <= cfg_wdata[15:0];
        ssi_pkg::CFG_COS:   cos_r   <= cfg_wdata[15:0];
        ssi_pkg::CFG_SCALE: scale_r <= cfg_wdata[15:0];
        ssi_pkg::CFG_NUM_V: nv_r    <= cfg_wdata[5:0];
        ssi_pkg::CFG_NUM_S: ns_r    <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // memories
  assign wr.vtx_we = in_acc && (in_data.op == ssi_pkg::OP_VERTEX);
  assign wr.seg_we = in_acc && (in_data.op == ssi_pkg::OP_SEGMENT);
  assign wr.slot   = in_data.slot;
  assign wr.x      = in_data.x;
  assign wr.y      = in_data.y;
  assign wr.first  = in_data.first_vertex;
  assign wr.second = in_data.second_vertex;

  assign s_idx = seg_mode_r ? seg_first : i_r[VAW-1:0];
  assign e_idx = seg_mode_r ? seg_second :
                 ((LW'(i_r + 1'b1) == n_r) ? '0 : VAW'(i_r + 1'b1));
  assign vtx_raddr = (state_r == ssi_pkg::ST_VA) ? s_idx : e_idx_r;

  ssi_store #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_store (
    .clk        (clk),
    .wr         (wr),
    .vtx_raddr  (vtx_raddr),
    .seg_raddr  (i_r[SAW-1:0]),
    .vtx_x_r    (vtx_x),
    .vtx_y_r    (vtx_y),
    .seg_first  (seg_first),
    .seg_second (seg_second)
  );

  // edge count for this query
  always_comb begin
    if (ns_r != '0) begin
      n_calc = (32'(ns_r) > MAX_SEGMENTS) ? LW'(MAX_SEGMENTS) : LW'(ns_r);
    end else begin
      n_calc = (32'(nv_r) > MAX_VERTICES) ? LW'(MAX_VERTICES) : LW'(nv_r);
    end
  end

  assign hit_now = (a1_r != '0) && (a2_r != '0) && (a1_r[AW-1] != a2_r[AW-1]) &&
                   (a3_r != '0) && (a4_r != '0) && (a3_r[AW-1] != a4_r[AW-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssi_pkg::ST_IDLE;
      step_r      <= '0;
      i_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      i_r     <= i_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    i_nxt     = i_r;
    load_out  = 1'b0;
    case (state_r)
      ssi_pkg::ST_IDLE: begin
        if (in_valid) begin
          i_nxt = '0;
          if ((in_data.op == ssi_pkg::OP_QUERY) && (n_calc != '0)) begin
            state_nxt = ssi_pkg::ST_SEG;
          end else begin
            state_nxt = ssi_pkg::ST_FIN;
          end
        end
      end
      ssi_pkg::ST_SEG: state_nxt = ssi_pkg::ST_VA;
      ssi_pkg::ST_VA:  state_nxt = ssi_pkg::ST_VB;
      ssi_pkg::ST_VB:  state_nxt = ssi_pkg::ST_VC;
      ssi_pkg::ST_VC: begin
        state_nxt = ssi_pkg::ST_CALC;
        step_nxt  = '0;
      end
      ssi_pkg::ST_CALC: begin
        if (step_r == ssi_pkg::CALC_LAST) begin
          step_nxt = '0;
          if (hit_now) begin
            state_nxt = ssi_pkg::ST_DIV;
          end else begin
            i_nxt = LW'(i_r + 1'b1);
            state_nxt = (LW'(i_r + 1'b1) == n_r) ? ssi_pkg::ST_FIN : ssi_pkg::ST_SEG;
          end
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      ssi_pkg::ST_DIV: begin
        if (step_r == ssi_pkg::DIV_LAST) begin
          step_nxt  = '0;
          state_nxt = ssi_pkg::ST_PT;
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      ssi_pkg::ST_PT: begin
        if (step_r == ssi_pkg::PT_LAST) state_nxt = ssi_pkg::ST_FIN;
        else step_nxt = step_r + 5'd1;
      end
      ssi_pkg::ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ssi_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ssi_pkg::ST_IDLE;
    endcase
  end

  // shared multiplier operand selection
  assign ux = step_r[3] ? vbx_r : vax_r;
  assign uy = step_r[3] ? vby_r : vay_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ssi_pkg::ST_CALC && !step_r[4]) begin
      case (step_r[2:0])
        3'd0: begin mul_a = 35'(ux); mul_b = 34'(cos_r); end
        3'd1: begin mul_a = 35'(uy); mul_b = 34'(sin_r); end
        3'd2: begin mul_a = 35'(uy); mul_b = 34'(cos_r); end
        3'd3: begin mul_a = 35'(ux); mul_b = 34'(sin_r); end
        3'd4, 3'd6: begin mul_a = rnd_r; mul_b = $signed({18'd0, scale_r}); end
        default: ;
      endcase
    end else if (state_r == ssi_pkg::ST_CALC) begin
      case (step_r[3:0])
        4'd0: begin
          mul_a = 35'(qx_r) - 35'(dx_r);  mul_b = 34'(qey_r) - 34'(dy_r);
        end
        4'd1: begin
          mul_a = 35'(qy_r) - 35'(dy_r);  mul_b = 34'(qex_r) - 34'(dx_r);
        end
        4'd2: begin
          mul_a = 35'(qx_r) - 35'(cx_r);  mul_b = 34'(qey_r) - 34'(cy_r);
        end
        4'd3: begin
          mul_a = 35'(qy_r) - 35'(cy_r);  mul_b = 34'(qex_r) - 34'(cx_r);
        end
        4'd4: begin
          mul_a = 35'(cx_r) - 35'(qx_r);  mul_b = 34'(dy_r) - 34'(qy_r);
        end
        4'd5: begin
          mul_a = 35'(cy_r) - 35'(qy_r);  mul_b = 34'(dx_r) - 34'(qx_r);
        end
        default: ;
      endcase
    end else if (state_r == ssi_pkg::ST_PT) begin
      case (step_r)
        5'd0: begin mul_a = 35'(qex_r) - 35'(qx_r); mul_b = $signed({18'd0, t_r}); end
        5'd1: begin mul_a = 35'(qey_r) - 35'(qy_r); mul_b = $signed({18'd0, t_r}); end
        default: ;
      endcase
    end
  end

  assign prod_w = AW'(prod_r);
  assign num_sh = num_r << 1;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (load_out) out_data_r <= '{res_hit_r, res_t_r, res_hx_r, res_hy_r};
    case (state_r)
      ssi_pkg::ST_IDLE: begin
        if (in_valid) begin
          qx_r       <= in_data.x;
          qy_r       <= in_data.y;
          qex_r      <= in_data.end_x;
          qey_r      <= in_data.end_y;
          seg_mode_r <= (ns_r != '0);
          n_r        <= n_calc;
          res_hit_r  <= 1'b0;
          res_t_r    <= '0;
          res_hx_r   <= '0;
          res_hy_r   <= '0;
        end
      end
      ssi_pkg::ST_VA: e_idx_r <= e_idx;
      ssi_pkg::ST_VB: begin
        vax_r <= vtx_x;
        vay_r <= vtx_y;
      end
      ssi_pkg::ST_VC: begin
        vbx_r <= vtx_x;
        vby_r <= vtx_y;
      end
      ssi_pkg::ST_CALC: begin
        if (!step_r[4]) begin
          // rotate, scale and translate one vertex
          case (step_r[2:0])
            3'd1: acc_r <= prod_w;
            3'd2: acc_r <= acc_r - prod_w;
            3'd3: begin
              rnd_r <= rnd14(acc_r);
              acc_r <= prod_w;
            end
            3'd4: acc_r <= acc_r + prod_w;
            3'd5: begin
              rnd_r <= rnd14(acc_r);
              if (step_r[3]) dx_r <= rnd_add(prod_r, pos_x_r, 1'b0);
              else cx_r <= rnd_add(prod_r, pos_x_r, 1'b0);
            end
            3'd7: begin
              if (step_r[3]) dy_r <= rnd_add(prod_r, pos_y_r, 1'b0);
              else cy_r <= rnd_add(prod_r, pos_y_r, 1'b0);
            end
            default: ;
          endcase
        end else begin
          // signed triangle areas
          case (step_r[3:0])
            4'd1, 4'd3, 4'd5: acc_r <= prod_w;
            4'd2: a1_r <= acc_r - prod_w;
            4'd4: a2_r <= acc_r - prod_w;
            4'd6: a3_r <= acc_r - prod_w;
            4'd7: begin
              a4_r <= a3_r + a2_r - a1_r;
              dd_r <= a1_r - a2_r;
            end
            4'd8: begin
              num_r <= {1'b0, absv(a3_r)};
              den_r <= absv(dd_r);
              t_r   <= '0;
            end
            default: ;
          endcase
        end
      end
      ssi_pkg::ST_DIV: begin
        if (num_sh >= {1'b0, den_r}) begin
          num_r <= num_sh - {1'b0, den_r};
          t_r   <= {t_r[14:0], 1'b1};
        end else begin
          num_r <= num_sh;
          t_r   <= {t_r[14:0], 1'b0};
        end
      end
      ssi_pkg::ST_PT: begin
        case (step_r)
          5'd1: res_hx_r <= rnd_add(prod_r, qx_r, 1'b1);
          5'd2: begin
            res_hy_r  <= rnd_add(prod_r, qy_r, 1'b1);
            res_hit_r <= 1'b1;
            res_t_r   <= t_r;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

### hdl/ssi_store.sv
// vertex and segment memories with registered reads
module ssi_store #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_SEGMENTS = 32,
  localparam int VAW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
  localparam int SAW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
  input  logic                      clk,
  input  ssi_pkg::store_wr_t        wr,
  input  logic [VAW-1:0]            vtx_raddr,
  input  logic [SAW-1:0]            seg_raddr,
  output logic signed [31:0]        vtx_x_r,
  output logic signed [31:0]        vtx_y_r,
  output logic [VAW-1:0]            seg_first,
  output logic [VAW-1:0]            seg_second
);

  logic signed [31:0] vx_mem [MAX_VERTICES];
  logic signed [31:0] vy_mem [MAX_VERTICES];
  logic [4:0]         sf_mem [MAX_SEGMENTS];
  logic [4:0]         se_mem [MAX_SEGMENTS];
  logic [4:0]         sf_r, se_r;
  logic [VAW-1:0]     mod_tab [32];

  // vertex index folded into the vertex range
  for (genvar g = 0; g < 32; g++) begin : g_mod
    assign mod_tab[g] = VAW'(g % MAX_VERTICES);
  end

  always_ff @(posedge clk) begin
    if (wr.vtx_we && (32'(wr.slot) < MAX_VERTICES)) begin
      vx_mem[VAW'(wr.slot)] <= wr.x;
      vy_mem[VAW'(wr.slot)] <= wr.y;
    end
    vtx_x_r <= vx_mem[vtx_raddr];
    vtx_y_r <= vy_mem[vtx_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr.seg_we && (32'(wr.slot) < MAX_SEGMENTS)) begin
      sf_mem[SAW'(wr.slot)] <= wr.first;
      se_mem[SAW'(wr.slot)] <= wr.second;
    end
    sf_r <= sf_mem[seg_raddr];
    se_r <= se_mem[seg_raddr];
  end

  assign seg_first  = mod_tab[sf_r];
  assign seg_second = mod_tab[se_r];

endmodule

### hdl/ssi_checker.sv
// port-level checks for the shape segment intersection block
module ssi_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input ssi_pkg::out_t out_data
);

  // result held while the receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while busy");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |->
      (out_data.t_out == '0) && (out_data.hit_x == '0) && (out_data.hit_y == '0))
    else $error("non-zero fields on a miss");

endmodule

bind shape_segment_intersection_top ssi_checker u_ssi_checker (.*);

### sim/tb_top.sv
// testbench for the shape segment intersection block: queued driver, checker, stall patterns
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;
  localparam int NV = 32;
  localparam int NS = 32;
  localparam int UNIT = 65536;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           cfg_we = 1'b0;
  logic [2:0]     cfg_index = '0;
  logic [31:0]    cfg_wdata = '0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  ssi_pkg::in_t   in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  ssi_pkg::out_t  out_data;

  shape_segment_intersection_top #(.MAX_VERTICES(NV), .MAX_SEGMENTS(NS)) dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow shape and pose
  int      shp_vx [NV];
  int      shp_vy [NV];
  int      shp_ss [NS];
  int      shp_se [NS];
  longint  pose_x, pose_y, rot_sin, rot_cos, pose_scale;
  int      cnt_v, cnt_s;

  ssi_pkg::in_t   pending_reqs [$];
  ssi_pkg::out_t  expected_hits [$];
  int      fail_cnt = 0;
  int      res_cnt = 0;
  bit      in_acc = 1'b0;

  function automatic longint rshift_round(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  function automatic void place_vertex(input int vx, input int vy, output int ox,
                                       output int oy);
    longint rx, ry;
    rx = rot_cos * vx - rot_sin * vy;
    ry = rot_cos * vy + rot_sin * vx;
    rx = rshift_round(rshift_round(rx, 14) * pose_scale, 8) + pose_x;
    ry = rshift_round(rshift_round(ry, 14) * pose_scale, 8) + pose_y;
    ox = sat32(rx);
    oy = sat32(ry);
  endfunction

  function automatic wide_t tri_area(longint ax, longint ay, longint bx, longint by,
                                     longint cx, longint cy);
    wide_t p0, p1, p2, p3;
    p0 = ax - cx;
    p1 = by - cy;
    p2 = ay - cy;
    p3 = bx - cx;
    return p0 * p1 - p2 * p3;
  endfunction

  function automatic int sgn(wide_t v);
    return (v < 0) ? -1 : ((v != 0) ? 1 : 0);
  endfunction

  function automatic bit edge_cross(input longint q[4], input int cx, input int cy,
                                    input int dx, input int dy,
                                    inout ssi_pkg::out_t r);
    wide_t a1, a2, a3, a4, num, den;
    logic [127:0] quo;
    longint t;
    a1 = tri_area(q[0], q[1], q[2], q[3], dx, dy);
    a2 = tri_area(q[0], q[1], q[2], q[3], cx, cy);
    if (sgn(a1) * sgn(a2) >= 0) return 1'b0;
    a3 = tri_area(cx, cy, dx, dy, q[0], q[1]);
    a4 = a3 + a2 - a1;
    if (sgn(a3) * sgn(a4) >= 0) return 1'b0;
    num = (a3 < 0) ? -a3 : a3;
    den = a3 - a4;
    if (den < 0) den = -den;
    quo = (128'(unsigned'(num)) << 16) / 128'(unsigned'(den));
    t = longint'(quo[15:0]);
    r.hit = 1'b1;
    r.t_out = quo[15:0];
    r.hit_x = sat32(q[0] + rshift_round(t * (q[2] - q[0]), 16));
    r.hit_y = sat32(q[1] + rshift_round(t * (q[3] - q[1]), 16));
    return 1'b1;
  endfunction

  function automatic ssi_pkg::out_t shape_hit_predict(ssi_pkg::in_t it);
    ssi_pkg::out_t r;
    longint q[4];
    int     n, s, e, cx, cy, dx, dy;
    r = '0;
    q[0] = it.x;
    q[1] = it.y;
    q[2] = it.end_x;
    q[3] = it.end_y;
    if (it.op == ssi_pkg::OP_VERTEX) begin
      shp_vx[it.slot] = it.x;
      shp_vy[it.slot] = it.y;
    end else if (it.op == ssi_pkg::OP_SEGMENT) begin
      shp_ss[it.slot] = it.first_vertex;
      shp_se[it.slot] = it.second_vertex;
    end else if (it.op == ssi_pkg::OP_QUERY) begin
      if (cnt_s > 0) begin
        n = (cnt_s > NS) ? NS : cnt_s;
        for (int i = 0; i < n; i++) begin
          s = shp_ss[i] % NV;
          e = shp_se[i] % NV;
          place_vertex(shp_vx[s], shp_vy[s], cx, cy);
          place_vertex(shp_vx[e], shp_vy[e], dx, dy);
          if (edge_cross(q, cx, cy, dx, dy, r)) break;
        end
      end else begin
        n = (cnt_v > NV) ? NV : cnt_v;
        for (int i = 0; i < n; i++) begin
          e = (i + 1) % n;
          place_vertex(shp_vx[i], shp_vy[i], cx, cy);
          place_vertex(shp_vx[e], shp_vy[e], dx, dy);
          if (edge_cross(q, cx, cy, dx, dy, r)) break;
        end
      end
    end
    return r;
  endfunction

  // acceptance and result checking
  always @(posedge clk) begin
    ssi_pkg::out_t exp_r;
    in_acc = rst_n && in_valid && !in_stall;
    if (in_acc) expected_hits.push_back(shape_hit_predict(in_data));
    if (rst_n && out_valid && !out_stall) begin
      res_cnt = res_cnt + 1;
      if (expected_hits.size() == 0) begin
        $error("result with no request outstanding");
        fail_cnt++;
      end else begin
        exp_r = expected_hits.pop_front();
        if (out_data.hit !== exp_r.hit) begin
          $error("hit: expected %0d actual %0d", exp_r.hit, out_data.hit);
          fail_cnt++;
        end
        if (out_data.t_out !== exp_r.t_out) begin
          $error("t_out: expected %0d actual %0d", exp_r.t_out, out_data.t_out);
          fail_cnt++;
        end
        if (out_data.hit_x !== exp_r.hit_x) begin
          $error("hit_x: expected %0d actual %0d", exp_r.hit_x, out_data.hit_x);
          fail_cnt++;
        end
        if (out_data.hit_y !== exp_r.hit_y) begin
          $error("hit_y: expected %0d actual %0d", exp_r.hit_y, out_data.hit_y);
          fail_cnt++;
        end
      end
    end
  end

  // request driver, bursts with gaps
  int burst_left = 1;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_data <= pending_reqs.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver stalls; one long hold-off to back up the input
  int  rx_cyc = 0;
  int  rx_mode = 0;
  int  hold_left = 0;
  bit  held = 1'b0;
  always @(negedge clk) begin
    rx_cyc++;
    if (rx_cyc % 97 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!held && res_cnt >= 50) begin
      held = 1'b1;
      hold_left = 600;
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        1: out_stall <= ($urandom_range(0, 1) == 0);
        2: out_stall <= ($urandom_range(0, 4) != 0);
        default: out_stall <= 1'b0;
      endcase
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      ssi_pkg::CFG_POS_X: pose_x = longint'(signed'(val));
      ssi_pkg::CFG_POS_Y: pose_y = longint'(signed'(val));
      ssi_pkg::CFG_SIN:   rot_sin = longint'(signed'(val[15:0]));
      ssi_pkg::CFG_COS:   rot_cos = longint'(signed'(val[15:0]));
      ssi_pkg::CFG_SCALE: pose_scale = longint'(val[15:0]);
      ssi_pkg::CFG_NUM_V: cnt_v = int'(val[5:0]);
      ssi_pkg::CFG_NUM_S: cnt_s = int'(val[5:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid || expected_hits.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_req(logic [1:0] op, int slot, int x, int y, int ex,
                          int ey, int fv, int sv);
    ssi_pkg::in_t it;
    it.op = op;
    it.slot = 5'(slot);
    it.x = x;
    it.y = y;
    it.end_x = ex;
    it.end_y = ey;
    it.first_vertex = 5'(fv);
    it.second_vertex = 5'(sv);
    pending_reqs.push_back(it);
  endtask

  function automatic int coord(int span);
    return $urandom_range(0, 2 * span * UNIT) - span * UNIT;
  endfunction

  function automatic int pick_count(int lo);
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return NV;
    if (k == 1) return $urandom_range(33, 63);
    if (k == 2) return $urandom_range(0, 2);
    return $urandom_range(lo, 8);
  endfunction

  initial begin
    int kind;
    pose_x = 0; pose_y = 0; rot_sin = 0; rot_cos = 16384; pose_scale = 256;
    cnt_v = 0; cnt_s = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fill every slot so no query touches an unloaded entry
    for (int i = 0; i < NV; i++)
      push_req(ssi_pkg::OP_VERTEX, i, coord(100), coord(100), $urandom, $urandom, 0, 0);
    for (int i = 0; i < NS; i++)
      push_req(ssi_pkg::OP_SEGMENT, i, $urandom, $urandom, $urandom, $urandom, i,
               (i + 1) % NV);
    // no vertices in use: no edges
    push_req(ssi_pkg::OP_QUERY, 0, -5 * UNIT, 5 * UNIT, 5 * UNIT, 5 * UNIT, 0, 0);
    wait_idle();

    // single vertex gives a zero length edge
    cfg_write(ssi_pkg::CFG_NUM_V, 1);
    push_req(ssi_pkg::OP_QUERY, 31, -500 * UNIT, -1, 500 * UNIT, 1, 31, 31);
    wait_idle();

    // triangle: crossing, vertex touch, collinear, unknown op, extremes
    cfg_write(ssi_pkg::CFG_NUM_V, 3);
    push_req(ssi_pkg::OP_VERTEX, 0, 0, 0, 0, 0, 0, 0);
    push_req(ssi_pkg::OP_VERTEX, 1, 10 * UNIT, 0, 0, 0, 0, 0);
    push_req(ssi_pkg::OP_VERTEX, 2, 0, 10 * UNIT, 0, 0, 0, 0);
    push_req(ssi_pkg::OP_QUERY, 0, -5 * UNIT, 5 * UNIT, 5 * UNIT, 5 * UNIT, 0, 0);
    push_req(ssi_pkg::OP_QUERY, 0, 1 * UNIT, 1 * UNIT, 20 * UNIT, 3 * UNIT, 0, 0);
    push_req(ssi_pkg::OP_QUERY, 0, -5 * UNIT, -5 * UNIT, 5 * UNIT, 5 * UNIT, 0, 0);
    push_req(ssi_pkg::OP_QUERY, 0, -5 * UNIT, 0, 20 * UNIT, 0, 0, 0);
    push_req(OP_UNUSED, 31, $urandom, $urandom, $urandom, $urandom, 31, 31);
    push_req(ssi_pkg::OP_QUERY, 31, 32'h80000000, 32'h80000000, 32'h7fffffff,
             32'h7fffffff, 31, 0);
    push_req(ssi_pkg::OP_QUERY, 0, 32'h7fffffff, 32'h80000000, 32'h80000000,
             32'h7fffffff, 0, 0);
    push_req(ssi_pkg::OP_VERTEX, 31, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0);
    push_req(ssi_pkg::OP_VERTEX, 30, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0);
    wait_idle();

    // explicit segments, one reaching the extreme vertices
    cfg_write(ssi_pkg::CFG_NUM_S, 2);
    push_req(ssi_pkg::OP_SEGMENT, 0, 0, 0, 0, 0, 1, 2);
    push_req(ssi_pkg::OP_SEGMENT, 1, 0, 0, 0, 0, 31, 30);
    push_req(ssi_pkg::OP_QUERY, 0, 0, 0, 20 * UNIT, 20 * UNIT, 0, 0);
    push_req(ssi_pkg::OP_QUERY, 0, 32'h80000000, 0, 32'h7fffffff, 1, 0, 0);
    wait_idle();

    // saturating pose extremes
    cfg_write(ssi_pkg::CFG_POS_X, 32'h7fffffff);
    cfg_write(ssi_pkg::CFG_POS_Y, 32'h80000000);
    cfg_write(ssi_pkg::CFG_SIN, 32'h00004000);
    cfg_write(ssi_pkg::CFG_COS, 32'h0000c000);
    cfg_write(ssi_pkg::CFG_SCALE, 32'h0000ffff);
    cfg_write(ssi_pkg::CFG_NUM_S, 0);
    push_req(ssi_pkg::OP_QUERY, 0, 32'h7fff0000, 32'h80010000, 32'h7ff00000,
             32'h80100000, 0, 0);
    push_req(ssi_pkg::OP_QUERY, 0, 32'h80000000, 32'h80000000, 32'h7fffffff,
             32'h7fffffff, 0, 0);
    wait_idle();

    for (int ph = 0; ph < 20; ph++) begin
      kind = $urandom_range(0, 4);
      if (kind == 0) begin
        cfg_write(ssi_pkg::CFG_POS_X,
                  ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000);
        cfg_write(ssi_pkg::CFG_POS_Y, $urandom);
        cfg_write(ssi_pkg::CFG_SIN,
                  ($urandom_range(0, 1) != 0) ? 32'h00004000 : 32'h0000c000);
        cfg_write(ssi_pkg::CFG_COS,
                  ($urandom_range(0, 1) != 0) ? 32'h00004000 : 32'h0000c000);
        cfg_write(ssi_pkg::CFG_SCALE,
                  ($urandom_range(0, 1) != 0) ? 32'h0000ffff : 32'h00000000);
      end else begin
        cfg_write(ssi_pkg::CFG_POS_X, coord(50));
        cfg_write(ssi_pkg::CFG_POS_Y, coord(50));
        cfg_write(ssi_pkg::CFG_SIN, $urandom_range(0, 32768) - 16384);
        cfg_write(ssi_pkg::CFG_COS, $urandom_range(0, 32768) - 16384);
        cfg_write(ssi_pkg::CFG_SCALE, (kind == 1) ? $urandom_range(0, 65535)
                                                  : $urandom_range(128, 512));
      end
      cfg_write(ssi_pkg::CFG_NUM_V, pick_count(3));
      cfg_write(ssi_pkg::CFG_NUM_S, ($urandom_range(0, 1) != 0) ? 0 : pick_count(1));
      for (int k = 0; k < 33; k++) begin
        int r;
        r = $urandom_range(0, 99);
        if (r < 22) begin
          if (r < 3) push_req(ssi_pkg::OP_VERTEX, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom);
          else push_req(ssi_pkg::OP_VERTEX, $urandom_range(0, 9), coord(100),
                        coord(100), $urandom, $urandom, $urandom, $urandom);
        end else if (r < 35) begin
          push_req(ssi_pkg::OP_SEGMENT, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom);
        end else if (r < 95) begin
          if (r < 40) push_req(ssi_pkg::OP_QUERY, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom, $urandom);
          else push_req(ssi_pkg::OP_QUERY, $urandom, coord(300), coord(300),
                        coord(300), coord(300), $urandom, $urandom);
        end else begin
          push_req(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom);
        end
      end
      wait_idle();
    end

    repeat (100) @(posedge clk);
    if (fail_cnt == 0 && expected_hits.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

### shape_segment_intersection_top.f
hdl/ssi_pkg.sv
hdl/ssi_store.sv
hdl/shape_segment_intersection_top.sv
hdl/ssi_checker.sv
sim/tb_top.sv
